FILE: sv/m3inv_pkg.sv
// Shared widths and constants for the 3x3 fixed-point matrix inverse.
package m3inv_pkg;

	localparam int EW            = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int THR_W         = 31;
	localparam int PW            = 2 * EW;
	localparam int CW            = PW + 1;
	localparam int MW            = 3 * EW;
	localparam int DW            = MW + 1;
	localparam int QB            = EW + 1;
	localparam int NLANE         = 9;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
	localparam logic [EW-1:0]    SAT_POS   = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0]    SAT_NEG   = {1'b1, {(EW-1){1'b0}}};

endpackage

FILE: sv/m3inv_in_if.sv
// Input channel carrying one 3x3 matrix.
interface m3inv_in_if;
	import m3inv_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [EW-1:0] in_r0c0;
	logic signed [EW-1:0] in_r0c1;
	logic signed [EW-1:0] in_r0c2;
	logic signed [EW-1:0] in_r1c0;
	logic signed [EW-1:0] in_r1c1;
	logic signed [EW-1:0] in_r1c2;
	logic signed [EW-1:0] in_r2c0;
	logic signed [EW-1:0] in_r2c1;
	logic signed [EW-1:0] in_r2c2;

	modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
		in_r2c0, in_r2c1, in_r2c2, input ready);
	modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
		in_r2c0, in_r2c1, in_r2c2, output ready);

endinterface

FILE: sv/m3inv_out_if.sv
// Output channel carrying one inverse matrix and its flags.
interface m3inv_out_if;
	import m3inv_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [EW-1:0] out_r0c0;
	logic signed [EW-1:0] out_r0c1;
	logic signed [EW-1:0] out_r0c2;
	logic signed [EW-1:0] out_r1c0;
	logic signed [EW-1:0] out_r1c1;
	logic signed [EW-1:0] out_r1c2;
	logic signed [EW-1:0] out_r2c0;
	logic signed [EW-1:0] out_r2c1;
	logic signed [EW-1:0] out_r2c2;
	logic                 singular;
	logic                 saturated;

	modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
		out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated, input ready);
	modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
		out_r1c2, out_r2c0, out_r2c1, out_r2c2, singular, saturated, output ready);

endinterface

FILE: sv/m3inv_cfg_if.sv
// Configuration write channel for the determinant threshold.
interface m3inv_cfg_if;
	import m3inv_pkg::*;

	logic             valid;
	logic             ready;
	logic [THR_W-1:0] det_threshold;

	modport source (output valid, det_threshold, input ready);
	modport sink (input valid, det_threshold, output ready);

endinterface

FILE: sv/matrix3_inverse.sv
// 3x3 fixed-point matrix inverse by adjugate with a pipelined restoring divider.
//
//  channel   | role | transfer carries
//  ----------+------+-----------------------------------------------
//  cfg       | sink | det_threshold, 31 bits
//  mat_in    | sink | nine signed Q entries, row-major
//  mat_out   | src  | nine signed Q entries, singular, saturated
//
//  One matrix per cycle unless stalled; seven stages for products, cofactors,
//  determinant and rounding, then one quotient bit per stage over 33 stages for all
//  nine lanes at once, then the output register.
//  All stages advance together when the output register is empty or taken; a stall
//  holds every stage. arst_n clears the valid bits and sets the threshold to 1.
module matrix3_inverse #(
	parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	m3inv_cfg_if.sink    cfg,
	m3inv_in_if.sink     mat_in,
	m3inv_out_if.source  mat_out
);
	import m3inv_pkg::*;

	localparam int RW   = MW + QB;
	localparam int RNDW = MW + 1;

	localparam int CA [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int CB [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int CC [NLANE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int CD [NLANE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	logic                    adv;
	logic [THR_W-1:0]        thr_q;
	logic signed [EW-1:0]    e_in [NLANE];

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [PW-1:0]    pa_s1 [NLANE];
	logic signed [PW-1:0]    pb_s1 [NLANE];
	logic signed [EW-1:0]    er_s1 [3];
	logic signed [CW-1:0]    cof_s2 [NLANE];
	logic signed [EW-1:0]    er_s2 [3];
	logic signed [CW-1:0]    cof_s3 [NLANE];
	logic signed [CW:0]      plo_s3 [3];
	logic signed [CW:0]      phi_s3 [3];
	logic signed [CW-1:0]    cof_s4 [NLANE];
	logic signed [DW-1:0]    term_s4 [3];
	logic signed [CW-1:0]    cof_s5 [NLANE];
	logic signed [DW-1:0]    det_s5;
	logic [PW-1:0]           cabs_s6 [NLANE];
	logic                    cneg_s6 [NLANE];
	logic                    dneg_s6;
	logic [MW-1:0]           mag_s6;
	logic [RNDW-1:0]         rnd;

	logic                    vld_sd  [QB+1];
	logic                    sing_sd [QB+1];
	logic [MW-1:0]           mag_sd  [QB+1];
	logic [RW-1:0]           rem_sd  [QB+1][NLANE];
	logic [QB-1:0]           qt_sd   [QB+1][NLANE];
	logic                    neg_sd  [QB+1][NLANE];
	logic                    ovf_sd  [QB+1][NLANE];

	logic [EW-1:0]           val_c [NLANE];
	logic                    sat_c;
	logic [EW-1:0]           val_q [NLANE];
	logic                    sat_q, sing_q, vld_q;

	assign adv          = !vld_q || mat_out.ready;
	assign mat_in.ready = adv;
	assign cfg.ready    = 1'b1;

	assign e_in[0] = mat_in.in_r0c0;
	assign e_in[1] = mat_in.in_r0c1;
	assign e_in[2] = mat_in.in_r0c2;
	assign e_in[3] = mat_in.in_r1c0;
	assign e_in[4] = mat_in.in_r1c1;
	assign e_in[5] = mat_in.in_r1c2;
	assign e_in[6] = mat_in.in_r2c0;
	assign e_in[7] = mat_in.in_r2c1;
	assign e_in[8] = mat_in.in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			thr_q <= cfg.det_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_sd[0] <= 1'b0;
		end else if (adv) begin
			vld_s1    <= mat_in.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_sd[0] <= vld_s6;
		end
	end

	// products, cofactors, determinant terms, determinant, magnitudes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NLANE; i++) begin
				pa_s1[i]   <= PW'(e_in[CA[i]]) * PW'(e_in[CB[i]]);
				pb_s1[i]   <= PW'(e_in[CC[i]]) * PW'(e_in[CD[i]]);
				cof_s2[i]  <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
				cof_s3[i]  <= cof_s2[i];
				cof_s4[i]  <= cof_s3[i];
				cof_s5[i]  <= cof_s4[i];
				cneg_s6[i] <= cof_s5[i][CW-1];
				cabs_s6[i] <= cof_s5[i][CW-1] ? PW'(-cof_s5[i]) : PW'(cof_s5[i]);
			end
			for (int j = 0; j < 3; j++) begin
				er_s1[j]   <= e_in[j];
				er_s2[j]   <= er_s1[j];
				plo_s3[j]  <= $signed({1'b0, cof_s2[3*j][EW-1:0]}) * er_s2[j];
				phi_s3[j]  <= $signed(cof_s2[3*j][CW-1:EW]) * er_s2[j];
				term_s4[j] <= (DW'(phi_s3[j]) <<< EW) + DW'(plo_s3[j]);
			end
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			dneg_s6 <= det_s5[DW-1];
			mag_s6  <= det_s5[DW-1] ? MW'(-det_s5) : MW'(det_s5);
		end
	end

	assign rnd = (RNDW'(mag_s6) + (RNDW'(1) << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);

	// rounding, singular test, overflow precheck and divider entry
	always_ff @(posedge clk) begin
		if (adv) begin
			sing_sd[0] <= rnd <= RNDW'(thr_q);
			mag_sd[0]  <= mag_s6;
			for (int i = 0; i < NLANE; i++) begin
				rem_sd[0][i] <= RW'(cabs_s6[i]) << (2*FRAC_BITS);
				qt_sd[0][i]  <= '0;
				neg_sd[0][i] <= cneg_s6[i] ^ dneg_s6;
				ovf_sd[0][i] <= (RW'(cabs_s6[i]) << (2*FRAC_BITS)) >= (RW'(mag_s6) << QB);
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [RW-1:0] dsh;
		logic          ge [NLANE];

		assign dsh = RW'(mag_sd[k]) << B;

		for (genvar i = 0; i < NLANE; i++) begin : g_lane
			assign ge[i] = rem_sd[k][i] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sing_sd[k+1] <= sing_sd[k];
				mag_sd[k+1]  <= mag_sd[k];
				for (int i = 0; i < NLANE; i++) begin
					rem_sd[k+1][i] <= ge[i] ? rem_sd[k][i] - dsh : rem_sd[k][i];
					qt_sd[k+1][i]  <= qt_sd[k][i] | (ge[i] ? (QB'(1) << B) : '0);
					neg_sd[k+1][i] <= neg_sd[k][i];
					ovf_sd[k+1][i] <= ovf_sd[k][i];
				end
			end
		end
	end

	// sign, clamp and singular mask
	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < NLANE; i++) begin
			if (!neg_sd[QB][i]) begin
				if (ovf_sd[QB][i] || qt_sd[QB][i][QB-1:EW-1] != '0) begin
					val_c[i] = SAT_POS;
					sat_c    = 1'b1;
				end else begin
					val_c[i] = qt_sd[QB][i][EW-1:0];
				end
			end else begin
				if (ovf_sd[QB][i] || qt_sd[QB][i] > (QB'(1) << (EW-1))) begin
					val_c[i] = SAT_NEG;
					sat_c    = 1'b1;
				end else begin
					val_c[i] = -qt_sd[QB][i][EW-1:0];
				end
			end
			if (sing_sd[QB]) begin
				val_c[i] = '0;
			end
		end
		if (sing_sd[QB]) begin
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_sd[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q  <= val_c;
			sat_q  <= sat_c;
			sing_q <= sing_sd[QB];
		end
	end

	assign mat_out.valid     = vld_q;
	assign mat_out.out_r0c0  = val_q[0];
	assign mat_out.out_r0c1  = val_q[1];
	assign mat_out.out_r0c2  = val_q[2];
	assign mat_out.out_r1c0  = val_q[3];
	assign mat_out.out_r1c1  = val_q[4];
	assign mat_out.out_r1c2  = val_q[5];
	assign mat_out.out_r2c0  = val_q[6];
	assign mat_out.out_r2c1  = val_q[7];
	assign mat_out.out_r2c2  = val_q[8];
	assign mat_out.singular  = sing_q;
	assign mat_out.saturated = sat_q;

endmodule

FILE: sv/m3inv_chk.sv
// Port checker for the matrix inverse, attached by bind.
module m3inv_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          singular,
	input logic          saturated,
	input logic [287:0]  out_all
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated && out_all == '0)
		else $error("singular result not cleared");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held with empty output");

	a_taken_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input held while output drains");

endmodule

bind matrix3_inverse m3inv_chk u_m3inv_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat_in.valid),
	.in_ready  (mat_in.ready),
	.out_valid (mat_out.valid),
	.out_ready (mat_out.ready),
	.singular  (mat_out.singular),
	.saturated (mat_out.saturated),
	.out_all   ({mat_out.out_r0c0, mat_out.out_r0c1, mat_out.out_r0c2,
		mat_out.out_r1c0, mat_out.out_r1c1, mat_out.out_r1c2,
		mat_out.out_r2c0, mat_out.out_r2c1, mat_out.out_r2c2})
);

FILE: sim/m3inv_checker.sv
// Checker for the 3x3 matrix inverse: predicts each inverse and compares it with the block's output.
module m3inv_checker (
	input  logic      clk,
	input  logic      arst_n,
	m3inv_cfg_if      cfg,
	m3inv_in_if       mat_in,
	m3inv_out_if      mat_out,
	output int        fail_count,
	output int        pending,
	output int        n_singular,
	output int        n_saturated
);
	import m3inv_pkg::*;

	typedef struct packed {
		logic [NLANE-1:0][EW-1:0] ent;
		logic                     singular;
		logic                     saturated;
	} inv_t;

	inv_t                expected_inverses[$];
	logic [THR_W-1:0]    threshold;

	function automatic inv_t predict_inverse(input logic signed [NLANE-1:0][EW-1:0] m,
		input logic [THR_W-1:0] thr);
		logic signed [127:0] e[9];
		logic signed [127:0] c[9];
		logic signed [127:0] det;
		logic [127:0]        mag;
		logic [127:0]        rnd;
		logic [127:0]        q;
		logic [127:0]        num;
		logic                neg;
		inv_t                r;
		for (int i = 0; i < 9; i++) e[i] = 128'($signed(m[i]));
		c[0] = e[4] * e[8] - e[5] * e[7];
		c[1] = e[2] * e[7] - e[1] * e[8];
		c[2] = e[1] * e[5] - e[2] * e[4];
		c[3] = e[5] * e[6] - e[3] * e[8];
		c[4] = e[0] * e[8] - e[2] * e[6];
		c[5] = e[2] * e[3] - e[0] * e[5];
		c[6] = e[3] * e[7] - e[4] * e[6];
		c[7] = e[1] * e[6] - e[0] * e[7];
		c[8] = e[0] * e[4] - e[1] * e[3];
		det = c[0] * e[0] + c[3] * e[1] + c[6] * e[2];
		mag = det[127] ? -det : det;
		rnd = (mag + (128'd1 << (2 * FRAC_BITS_DEF - 1))) >> (2 * FRAC_BITS_DEF);
		r = '0;
		if (rnd <= 128'(thr) || mag == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int i = 0; i < 9; i++) begin
			neg = c[i][127] != det[127];
			num = (c[i][127] ? -c[i] : c[i]) << (2 * FRAC_BITS_DEF);
			q = num / mag;
			if (!neg) begin
				if (q > 128'h7FFF_FFFF) begin
					r.ent[i] = SAT_POS;
					r.saturated = 1'b1;
				end else begin
					r.ent[i] = q[EW-1:0];
				end
			end else begin
				if (q > 128'h8000_0000) begin
					r.ent[i] = SAT_NEG;
					r.saturated = 1'b1;
				end else begin
					r.ent[i] = EW'(-q[EW-1:0]);
				end
			end
		end
		return r;
	endfunction

	assign pending = expected_inverses.size();

	always @(posedge clk or negedge arst_n) begin
		inv_t got;
		inv_t exp_inv;
		if (!arst_n) begin
			threshold   <= THR_RESET;
			fail_count  <= 0;
			n_singular  <= 0;
			n_saturated <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				threshold <= cfg.det_threshold;
			if (mat_in.valid && mat_in.ready)
				expected_inverses.push_back(predict_inverse({mat_in.in_r2c2, mat_in.in_r2c1,
					mat_in.in_r2c0, mat_in.in_r1c2, mat_in.in_r1c1, mat_in.in_r1c0,
					mat_in.in_r0c2, mat_in.in_r0c1, mat_in.in_r0c0}, threshold));
			if (mat_out.valid && mat_out.ready) begin
				got.ent = {mat_out.out_r2c2, mat_out.out_r2c1, mat_out.out_r2c0,
					mat_out.out_r1c2, mat_out.out_r1c1, mat_out.out_r1c0,
					mat_out.out_r0c2, mat_out.out_r0c1, mat_out.out_r0c0};
				got.singular  = mat_out.singular;
				got.saturated = mat_out.saturated;
				if (expected_inverses.size() == 0) begin
					$display("%0t: unexpected transfer, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_inv = expected_inverses.pop_front();
					n_singular  <= n_singular + exp_inv.singular;
					n_saturated <= n_saturated + exp_inv.saturated;
					if (got !== exp_inv) begin
						for (int i = 0; i < 9; i++)
							if (got.ent[i] !== exp_inv.ent[i])
								$display("%0t: entry %0d expected %h actual %h", $time, i,
									exp_inv.ent[i], got.ent[i]);
						if (got.singular !== exp_inv.singular)
							$display("%0t: singular expected %b actual %b", $time,
								exp_inv.singular, got.singular);
						if (got.saturated !== exp_inv.saturated)
							$display("%0t: saturated expected %b actual %b", $time,
								exp_inv.saturated, got.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: sim/tb_matrix3_inverse.sv
// Testbench top for the 3x3 matrix inverse: stimulus, idling phases and verdict.
module tb_matrix3_inverse;
	import m3inv_pkg::*;

	localparam logic [EW-1:0] ONE   = 32'h0001_0000;
	localparam int            LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   n_singular;
	int   n_saturated;
	int   n_items;
	int   cycle;
	int   send_idle;
	int   recv_stall;

	m3inv_cfg_if cfg();
	m3inv_in_if  mat_in();
	m3inv_out_if mat_out();

	matrix3_inverse i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.mat_in  (mat_in),
		.mat_out (mat_out)
	);

	m3inv_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.mat_in      (mat_in),
		.mat_out     (mat_out),
		.fail_count  (fail_count),
		.pending     (pending),
		.n_singular  (n_singular),
		.n_saturated (n_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > LIMIT) begin
				$display("timeout after %0d cycles", cycle);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver: stall at the current rate
	always @(negedge clk)
		mat_out.ready <= ($urandom_range(99) >= recv_stall);

	function automatic logic [EW-1:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom;
			1: return EW'(int'($urandom_range(6)) - 3) << 16;
			2: return EW'($urandom_range(65535)) - 32'h8000;
			3: begin
				case ($urandom_range(3))
					0: return SAT_POS;
					1: return SAT_NEG;
					2: return '0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return EW'(int'($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	// hold valid across back-to-back transfers, drop it only while idling
	task automatic send_matrix(input logic [NLANE-1:0][EW-1:0] m);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			mat_in.valid <= 1'b0;
			@(negedge clk);
		end
		mat_in.valid   <= 1'b1;
		{mat_in.in_r2c2, mat_in.in_r2c1, mat_in.in_r2c0, mat_in.in_r1c2, mat_in.in_r1c1,
			mat_in.in_r1c0, mat_in.in_r0c2, mat_in.in_r0c1, mat_in.in_r0c0} <= m;
		do @(posedge clk); while (!mat_in.ready);
		n_items++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		mat_in.valid <= 1'b0;
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] thr);
		stop_sending();
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		cfg.valid         <= 1'b1;
		cfg.det_threshold <= thr;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [NLANE-1:0][EW-1:0] diag(input logic [EW-1:0] a,
		input logic [EW-1:0] b, input logic [EW-1:0] c);
		logic [NLANE-1:0][EW-1:0] m;
		m = '0;
		m[0] = a;
		m[4] = b;
		m[8] = c;
		return m;
	endfunction

	task automatic random_phase(input int count, input int idle, input int stall);
		logic [NLANE-1:0][EW-1:0] m;
		send_idle  = idle;
		recv_stall = stall;
		for (int k = 0; k < count; k++) begin
			for (int i = 0; i < 9; i++) m[i] = rand_entry();
			// make some rows dependent to reach singular cases
			if ($urandom_range(9) == 0) m[8:6] = m[2:0];
			send_matrix(m);
		end
	endtask

	initial begin
		logic [NLANE-1:0][EW-1:0] m;
		arst_n            = 1'b0;
		mat_in.valid      = 1'b0;
		{mat_in.in_r0c0, mat_in.in_r0c1, mat_in.in_r0c2, mat_in.in_r1c0, mat_in.in_r1c1,
			mat_in.in_r1c2, mat_in.in_r2c0, mat_in.in_r2c1, mat_in.in_r2c2} = '0;
		mat_out.ready     = 1'b0;
		cfg.valid         = 1'b0;
		cfg.det_threshold = '0;
		send_idle         = 0;
		recv_stall        = 0;
		n_items           = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, scalings, zero, extremes, tie rounding
		send_matrix(diag(ONE, ONE, ONE));
		send_matrix(diag(32'hFFFF_0000, ONE << 1, ONE));
		send_matrix('0);
		send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
		send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0200));
		send_matrix(diag(SAT_NEG, SAT_NEG, SAT_NEG));
		send_matrix(diag(SAT_POS, SAT_POS, SAT_POS));
		send_matrix(diag(SAT_NEG, SAT_POS, 32'h0000_0001));
		send_matrix(diag(ONE, ONE, 32'h0000_8000));
		send_matrix(diag(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_matrix({9{SAT_NEG}});
		send_matrix({9{SAT_POS}});
		m = {ONE, ONE << 1, ONE * 3, ONE << 2, ONE * 5, ONE * 6, ONE * 7, ONE << 3,
			ONE * 10};
		send_matrix(m);
		send_matrix(diag(ONE, ONE, 32'h0001_8000));
		write_threshold('0);
		send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
		send_matrix(diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0080));
		send_matrix('0);
		write_threshold({THR_W{1'b1}});
		send_matrix(diag(SAT_NEG, SAT_NEG, SAT_NEG));
		send_matrix(diag(ONE, ONE, ONE));

		write_threshold(THR_RESET);
		random_phase(250, 0, 0);
		write_threshold('0);
		random_phase(200, 59, 0);
		write_threshold(THR_W'($urandom_range(1000)));
		random_phase(200, 0, 59);
		write_threshold(THR_W'($urandom));
		random_phase(50, 18, 18);
		write_threshold(THR_W'(2));
		random_phase(200, 18, 18);

		stop_sending();
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("%0d matrices checked over five idling phases and five thresholds", n_items);
		$display("%0d singular, %0d saturated", n_singular, n_saturated);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
